### hdl/ckd_pkg.sv
// Card key derivation package: round table, stage constants and mixing functions.
`timescale 1ns / 1ps

package ckd_pkg;

    localparam int unsigned NUM_ROUNDS       = 8;
    localparam int unsigned NUM_STAGES       = 4;
    localparam int unsigned ROUNDS_PER_STAGE = NUM_ROUNDS / NUM_STAGES;

    typedef logic [1:0] byte_idx_t;

    // ka/kb: key bytes; p/q: bytes added; u/v: bytes xored in; dm/dn: bytes written
    typedef struct packed {
        byte_idx_t ka;
        byte_idx_t kb;
        byte_idx_t p;
        byte_idx_t q;
        byte_idx_t u;
        byte_idx_t v;
        byte_idx_t dm;
        byte_idx_t dn;
    } round_t;

    localparam round_t ROUND_TABLE [NUM_ROUNDS] = '{
        '{ka: 2'd0, kb: 2'd1, p: 2'd2, q: 2'd3, u: 2'd0, v: 2'd1, dm: 2'd0, dn: 2'd1},
        '{ka: 2'd1, kb: 2'd2, p: 2'd0, q: 2'd1, u: 2'd2, v: 2'd3, dm: 2'd2, dn: 2'd3},
        '{ka: 2'd2, kb: 2'd3, p: 2'd1, q: 2'd0, u: 2'd3, v: 2'd2, dm: 2'd2, dn: 2'd3},
        '{ka: 2'd0, kb: 2'd3, p: 2'd2, q: 2'd3, u: 2'd1, v: 2'd0, dm: 2'd0, dn: 2'd1},
        '{ka: 2'd0, kb: 2'd3, p: 2'd3, q: 2'd2, u: 2'd1, v: 2'd0, dm: 2'd0, dn: 2'd1},
        '{ka: 2'd2, kb: 2'd3, p: 2'd0, q: 2'd1, u: 2'd3, v: 2'd2, dm: 2'd2, dn: 2'd3},
        '{ka: 2'd1, kb: 2'd2, p: 2'd1, q: 2'd0, u: 2'd3, v: 2'd2, dm: 2'd2, dn: 2'd3},
        '{ka: 2'd0, kb: 2'd1, p: 2'd2, q: 2'd3, u: 2'd1, v: 2'd0, dm: 2'd0, dn: 2'd1}
    };

    // One round: all terms read before either byte is written
    function automatic logic [31:0] apply_round(
        input logic   [31:0] key,
        input logic   [31:0] y,
        input round_t        r
    );
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  m;
        logic [7:0]  n;
        logic [31:0] res;
        a   = key[8*r.ka +: 8];
        b   = key[8*r.kb +: 8];
        m   = ((a ^ b) + y[8*r.p +: 8]) ^ y[8*r.u +: 8];
        n   = (a + b + y[8*r.q +: 8]) ^ y[8*r.v +: 8];
        res = y;
        res[8*r.dm +: 8] = m;
        res[8*r.dn +: 8] = n;
        return res;
    endfunction

    // The rounds that belong to one pipeline stage
    function automatic logic [31:0] apply_stage(
        input logic [31:0] key,
        input logic [31:0] y,
        input int unsigned stage
    );
        logic [31:0] acc;
        acc = y;
        for (int unsigned i = 0; i < ROUNDS_PER_STAGE; i++) begin
            acc = apply_round(key, acc, ROUND_TABLE[stage * ROUNDS_PER_STAGE + i]);
        end
        return acc;
    endfunction

endpackage

### hdl/card_key_derivation.sv
// Card key derivation top level: four-stage mixing pipeline for both key halves.
// Accepted inputs pass through stage registers 0, 1, 2 and 3 in turn; out_valid is stage 3's valid bit.
// Throughput: one transaction per cycle while the output is not stalled; each stage holds two of the eight rounds.
// A stall at the output backs up stage by stage; bubbles are filled while stalled.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears work_key.
`timescale 1ns / 1ps

module card_key_derivation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        work_key_we,
    input  logic [31:0] work_key,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] text_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] key_first_half,
    output logic [31:0] key_second_half
);

    localparam int unsigned NS = ckd_pkg::NUM_STAGES;

    logic [31:0] work_key_reg;

    logic [NS-1:0] valid_reg;
    logic [31:0]   first_reg  [NS];
    logic [31:0]   second_reg [NS];

    logic [NS:0]   adv;
    logic [NS-1:0] valid_in;
    logic [31:0]   first_in   [NS];
    logic [31:0]   second_in  [NS];
    logic [31:0]   first_next [NS];
    logic [31:0]   second_next[NS];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            work_key_reg <= '0;
        end
        else if (work_key_we) begin
            work_key_reg <= work_key;
        end
    end

    // A stage moves on when it is empty or the next one moves on
    assign adv[NS] = out_ready;

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            assign adv[s] = !valid_reg[s] || adv[s+1];

            if (s == 0) begin : g_head
                assign valid_in[s]  = in_valid;
                assign first_in[s]  = text_word;
                assign second_in[s] = ~text_word;
            end
            else begin : g_body
                assign valid_in[s]  = valid_reg[s-1];
                assign first_in[s]  = first_reg[s-1];
                assign second_in[s] = second_reg[s-1];
            end

            always_comb
            begin
                first_next[s]  = ckd_pkg::apply_stage(work_key_reg, first_in[s], s);
                second_next[s] = ckd_pkg::apply_stage(work_key_reg, second_in[s], s);
            end

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    valid_reg[s] <= 1'b0;
                end
                else if (adv[s]) begin
                    valid_reg[s] <= valid_in[s];
                end
            end

            always_ff @(posedge clk) begin
                if (adv[s] && valid_in[s]) begin
                    first_reg[s]  <= first_next[s];
                    second_reg[s] <= second_next[s];
                end
            end
        end
    endgenerate

    assign in_ready        = adv[0];
    assign out_valid       = valid_reg[NS-1];
    assign key_first_half  = first_reg[NS-1];
    assign key_second_half = second_reg[NS-1];

    // An output that is being taken never holds back the input
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is drained");

    // An accepted transaction always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted transaction lost at first stage");

    // A stalled middle stage (stage 1) keeps its contents
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && !adv[1]) |=> (valid_reg[1] && $stable(first_reg[1])
                                       && $stable(second_reg[1])))
        else $error("stalled stage changed");

endmodule
